>>> rtl/iahbc_pkg.sv
package iahbc_pkg;

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    localparam logic [4:0] NO_DIGIT = 5'd16;
    localparam logic [32:0] SAT_LIMIT = 33'h1_0000_0000;

    localparam logic REG_STRICT_MODE = 1'b0;

    typedef enum logic [1:0] {
        RADIX_DEC  = 2'd0,
        RADIX_OCT  = 2'd1,
        RADIX_HEX  = 2'd2,
        RADIX_ZERO = 2'd3
    } t_radix;

    typedef struct packed {
        logic [32:0]      part_value;
        logic [2:0]       part_index;
        logic [1:0]       chars_in_part;
        t_radix           radix;
        logic [2:0][7:0]  saved_octets;
        logic             parse_failed;
    } t_parse_state;

    typedef struct packed {
        logic        is_numeric;
        logic        blocked;
        logic [31:0] address;
        logic [2:0]  parts_seen;
    } t_result;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = {1'b0, c[3:0]};
        end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                     (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
            d = {1'b0, c[3:0]} + 5'd9;
        end else begin
            d = NO_DIGIT;
        end
        return d;
    endfunction

endpackage

>>> rtl/iahbc_step.sv
module iahbc_step
    import iahbc_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_char,
    input  logic         i_last,
    input  logic         i_strict,
    output t_parse_state o_state,
    output t_result      o_result
);

    logic [4:0]   digit;
    logic [4:0]   base;
    logic         do_acc;
    logic [36:0]  prod;
    logic [36:0]  sum;
    t_parse_state mid;
    logic         fail_end;
    logic         too_big;
    logic         ok;
    logic [31:0]  addr;
    logic [7:0]   b0;
    logic [7:0]   b1;
    logic [7:0]   b2;
    logic         in_range;

    assign digit = digit_of(i_char);

    // one character or dot against the current part
    always_comb begin
        mid    = i_state;
        do_acc = 1'b0;
        base   = 5'd10;
        prod   = '0;
        sum    = '0;
        if (i_char == CH_DOT) begin
            if (i_state.chars_in_part == 2'd0) begin
                mid.parse_failed = 1'b1;
            end
            if (i_state.radix == RADIX_HEX && i_state.chars_in_part == 2'd2) begin
                mid.parse_failed = 1'b1;
            end
            if (i_state.part_index < 3'd3 && i_state.part_value <= 33'h0_0000_00FF) begin
                mid.saved_octets[i_state.part_index[1:0]] = i_state.part_value[7:0];
            end else begin
                mid.parse_failed = 1'b1;
            end
            if (i_state.part_index != 3'd7) begin
                mid.part_index = i_state.part_index + 3'd1;
            end
            mid.part_value    = '0;
            mid.chars_in_part = '0;
            mid.radix         = RADIX_DEC;
        end else begin
            if (i_state.chars_in_part == 2'd0) begin
                if (i_char == CH_ZERO) begin
                    mid.radix      = RADIX_ZERO;
                    mid.part_value = '0;
                end else begin
                    mid.radix = RADIX_DEC;
                    do_acc    = 1'b1;
                end
            end else begin
                case (i_state.radix)
                    RADIX_ZERO: begin
                        if (i_char == CH_LOWER_X || i_char == CH_UPPER_X) begin
                            mid.radix      = RADIX_HEX;
                            mid.part_value = '0;
                        end else begin
                            mid.radix = RADIX_OCT;
                            do_acc    = 1'b1;
                            base      = 5'd8;
                        end
                    end
                    RADIX_HEX: begin
                        do_acc = 1'b1;
                        base   = 5'd16;
                    end
                    RADIX_OCT: begin
                        do_acc = 1'b1;
                        base   = 5'd8;
                    end
                    default: begin
                        do_acc = 1'b1;
                    end
                endcase
            end
            case (base)
                5'd8:    prod = {1'b0, i_state.part_value, 3'b000};
                5'd16:   prod = {i_state.part_value, 4'b0000};
                default: prod = {1'b0, i_state.part_value, 3'b000}
                                + {3'b000, i_state.part_value, 1'b0};
            endcase
            sum = prod + {32'd0, digit};
            if (do_acc) begin
                if (digit >= base) begin
                    mid.parse_failed = 1'b1;
                end else if (sum > {4'd0, SAT_LIMIT}) begin
                    mid.part_value = SAT_LIMIT;
                end else begin
                    mid.part_value = sum[32:0];
                end
            end
            if (i_state.chars_in_part != 2'd3) begin
                mid.chars_in_part = i_state.chars_in_part + 2'd1;
            end
        end
    end

    // end of name: close the last part and assemble
    always_comb begin
        fail_end = mid.parse_failed || mid.chars_in_part == 2'd0 ||
                   (mid.radix == RADIX_HEX && mid.chars_in_part == 2'd2) ||
                   mid.part_index > 3'd3;
        case (mid.part_index[1:0])
            2'd0:    too_big = mid.part_value[32];
            2'd1:    too_big = mid.part_value[32:24] != '0;
            2'd2:    too_big = mid.part_value[32:16] != '0;
            default: too_big = mid.part_value[32:8] != '0;
        endcase
        ok = !fail_end && !too_big;
        case (mid.part_index[1:0])
            2'd0:    addr = mid.part_value[31:0];
            2'd1:    addr = {mid.saved_octets[0], mid.part_value[23:0]};
            2'd2:    addr = {mid.saved_octets[0], mid.saved_octets[1],
                             mid.part_value[15:0]};
            default: addr = {mid.saved_octets[0], mid.saved_octets[1],
                             mid.saved_octets[2], mid.part_value[7:0]};
        endcase
        if (!ok) begin
            addr = '0;
        end
    end

    assign b0 = addr[31:24];
    assign b1 = addr[23:16];
    assign b2 = addr[15:8];

    always_comb begin
        in_range = 1'b0;
        if (b0 == 8'd0 || b0 == 8'd10) in_range = 1'b1;
        if (b0 == 8'd100 && b1 >= 8'd64 && b1 <= 8'd127) in_range = 1'b1;
        if (i_strict && b0 == 8'd127) in_range = 1'b1;
        if (b0 == 8'd169 && b1 == 8'd254) in_range = 1'b1;
        if (b0 == 8'd172 && b1 >= 8'd16 && b1 <= 8'd31) in_range = 1'b1;
        if (b0 == 8'd192 && b1 == 8'd168) in_range = 1'b1;
        if (b0 == 8'd192 && b1 == 8'd0 && (b2 == 8'd0 || b2 == 8'd2)) in_range = 1'b1;
        if (b0 == 8'd198 && (b1 == 8'd18 || b1 == 8'd19)) in_range = 1'b1;
        if (b0 == 8'd198 && b1 == 8'd51 && b2 == 8'd100) in_range = 1'b1;
        if (b0 == 8'd203 && b1 == 8'd0 && b2 == 8'd113) in_range = 1'b1;
        if (b0 >= 8'd240) in_range = 1'b1;
    end

    always_comb begin
        o_result.is_numeric = ok;
        o_result.blocked    = ok && in_range;
        o_result.address    = addr;
        o_result.parts_seen = (mid.part_index == 3'd7) ? 3'd7 : mid.part_index + 3'd1;
        o_state             = i_last ? '0 : mid;
    end

endmodule

>>> rtl/inet_aton_host_blocklist_check_top.sv
// channel  direction  handshake                 payload
// in       to block   i_in_valid / o_in_stall   i_host_char, i_last_char
// out      from block o_out_valid / i_out_stall o_is_numeric, o_blocked, o_address,
//                                               o_parts_seen
// cfg      to block   apb psel/penable/pwrite   strict_mode at byte address 0
//
// one character per cycle unless stalled: input register, then the parse step
// loads the state registers and, on the last character, the result register
// the result register loads as the last character leaves the input register
// reset sets strict_mode to 1 and clears the parse state and both valids
// an out stall only holds back a last character while a result is still waiting
module inet_aton_host_blocklist_check_top
    import iahbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_host_char,
    input  logic        i_last_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_numeric,
    output logic        o_blocked,
    output logic [31:0] o_address,
    output logic [2:0]  o_parts_seen,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic         r_strict;
    logic         n_strict;
    logic         r_in_valid;
    logic         n_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;
    t_parse_state r_state;
    t_parse_state n_state;
    t_result      step_result;
    logic         r_out_valid;
    logic         n_out_valid;
    t_result      r_result;
    logic         proceed;
    logic         in_take;

    iahbc_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .i_strict (r_strict),
        .o_state  (n_state),
        .o_result (step_result)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STRICT_MODE) ? {31'd0, r_strict} : 32'd0;

    assign proceed    = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proceed;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_strict = r_strict;
        if (psel && penable && pwrite && paddr[2] == REG_STRICT_MODE) begin
            n_strict = pwdata[0];
        end
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (proceed) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (proceed && r_in_last) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict    <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_strict    <= n_strict;
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (proceed) begin
                r_state <= n_state;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_host_char;
            r_in_last <= i_last_char;
        end
        if (proceed && r_in_last) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_numeric = r_result.is_numeric;
    assign o_blocked    = r_result.blocked;
    assign o_address    = r_result.address;
    assign o_parts_seen = r_result.parts_seen;

endmodule

>>> rtl/iahbc_checker.sv
module iahbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_is_numeric,
    input logic        o_blocked,
    input logic [31:0] o_address,
    input logic [2:0]  o_parts_seen
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_address) &&
            $stable(o_is_numeric) && $stable(o_blocked) && $stable(o_parts_seen))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    a_non_numeric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_numeric |-> o_address == 32'd0 && !o_blocked)
        else $error("non-numeric result carries address or block");

    a_numeric_parts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_numeric |-> o_parts_seen != 3'd0 && o_parts_seen <= 3'd4)
        else $error("numeric result with bad part count");

    a_zero_net: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_numeric && o_address[31:24] == 8'd0 |-> o_blocked)
        else $error("zero network not blocked");

endmodule

bind inet_aton_host_blocklist_check_top iahbc_checker u_checker (.*);
